// ===== rtl/va3_pkg.sv =====
// Package for the three-component vector ALU.
// Holds the shared types, latency constants, saturation helper and the acos table.
// No dependencies; every file in rtl/ imports it.
package va3_pkg;

  localparam int FracBits = 16;
  localparam int ZeroTol  = 1;

  // Pipeline depths of the arithmetic units.
  localparam int DivSteps = 32;
  localparam int DivLat   = DivSteps + 1;
  localparam int SqrtLat  = 32;
  localparam int PolySteps = 7;
  localparam int PolyLat  = 2 * PolySteps;
  localparam int LaneLat  = DivLat + 2;
  localparam int DotLat   = 3;
  localparam int AngLat   = 2 * SqrtLat + DivLat + 8;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegDefX = 3'd1;
  localparam logic [2:0] RegDefY = 3'd2;
  localparam logic [2:0] RegDefZ = 3'd3;
  localparam logic [2:0] RegADef = 3'd4;
  localparam logic [2:0] RegBDef = 3'd5;

  typedef enum logic [2:0] {
    MODE_DOT   = 3'd0,
    MODE_CROSS = 3'd1,
    MODE_ADD   = 3'd2,
    MODE_SUB   = 3'd3,
    MODE_MUL   = 3'd4,
    MODE_DIV   = 3'd5,
    MODE_ANGLE = 3'd6
  } mode_e;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } div_tag_t;

  localparam logic signed [65:0] WordMax  = 66'sd2147483647;
  localparam logic signed [65:0] WordMin  = -66'sd2147483648;
  localparam logic signed [65:0] HalfFrac = 66'sd1 <<< (FracBits - 1);
  localparam logic signed [65:0] HalfQ30  = 66'sd1 <<< 29;
  localparam logic signed [65:0] OneQ30   = 66'sd1 <<< 30;
  localparam logic [30:0]        Q30One   = 31'd1 << 30;
  localparam logic signed [33:0] PiQ30    = 34'sd3373259426;
  localparam logic signed [33:0] DegQ24   = 34'sd961263669;
  localparam int                 DegShift = 54 - FracBits;
  localparam logic signed [67:0] HalfDeg  = 68'sd1 <<< (DegShift - 1);

  // Coefficients of the acos approximation sqrt(1-x)*P(x), Q30.
  localparam logic signed [33:0] AcosPoly [8] = '{
    34'sd1686629690, -34'sd230423709, 34'sd95540460, -34'sd53874249,
    34'sd33169905, -34'sd18348235, 34'sd7161955, -34'sd1355589
  };

  function automatic word_t sat32(input logic signed [65:0] v);
    word_t r;
    if (v > WordMax) begin
      r = 32'sh7fffffff;
    end else if (v < WordMin) begin
      r = 32'sh80000000;
    end else begin
      r = word_t'(v[31:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/va3_sqrt.sv =====
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// Depends on va3_pkg.
module va3_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import va3_pkg::*;

  logic [34:0] rem_q  [SqrtLat];
  logic [31:0] root_q [SqrtLat];
  logic [63:0] rad_q  [SqrtLat];

  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // The remainder never exceeds twice the root, so its top bits are zero.
    assign rem_sh = {rem_in[32:0], rad_in[63:62]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[30:0], 1'b0};
        end
        rad_q[k] <= {rad_in[61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SqrtLat-1];

endmodule

// ===== rtl/va3_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with signed saturated result.
// The dividend must be below the divisor shifted up by 32. Depends on va3_pkg.
module va3_div (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [63:0]       num_i,
  input  logic [32:0]       den_i,
  input  va3_pkg::div_tag_t tag_i,
  output va3_pkg::word_t    quo_o
);
  import va3_pkg::*;

  logic [32:0] rem_q [DivSteps];
  logic [31:0] lo_q  [DivSteps];
  logic [31:0] quo_q [DivSteps];
  logic [32:0] den_q [DivSteps];
  div_tag_t    tag_q [DivSteps];
  word_t       res_q;
  word_t       res_d;

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic [32:0] rem_in;
    logic [31:0] lo_in;
    logic [31:0] quo_in;
    logic [32:0] den_in;
    div_tag_t    tag_in;
    logic [33:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num_i[63:32]};
      assign lo_in  = num_i[31:0];
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, lo_in[31]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, den_in}) begin
          rem_q[k] <= 33'(trial - {1'b0, den_in});
          quo_q[k] <= {quo_in[30:0], 1'b1};
        end else begin
          rem_q[k] <= trial[32:0];
          quo_q[k] <= {quo_in[30:0], 1'b0};
        end
        lo_q[k]  <= {lo_in[30:0], 1'b0};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  always_comb begin
    logic [31:0] q;
    div_tag_t    t;
    q = quo_q[DivSteps-1];
    t = tag_q[DivSteps-1];
    if (t.zero) begin
      res_d = '0;
    end else if (t.ovf) begin
      res_d = t.neg ? 32'sh80000000 : 32'sh7fffffff;
    end else if (t.neg) begin
      res_d = (q > 32'h80000000) ? 32'sh80000000 : word_t'(~q + 32'd1);
    end else begin
      res_d = q[31] ? 32'sh7fffffff : word_t'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

// ===== rtl/va3_lane.sv =====
// One component lane: add, subtract, multiply, cross term and guarded divide.
// Also hands its raw product to the merge stage for the dot product. Depends on va3_pkg, va3_div.
module va3_lane (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  va3_pkg::mode_e       mode_i,
  input  va3_pkg::word_t       a_i,
  input  va3_pkg::word_t       b_i,
  input  va3_pkg::word_t       aj_i,
  input  va3_pkg::word_t       bk_i,
  input  va3_pkg::word_t       ak_i,
  input  va3_pkg::word_t       bj_i,
  output va3_pkg::word_t       vec_o,
  output logic signed [63:0]   prod_o
);
  import va3_pkg::*;

  logic [31:0] mag_a;
  logic [31:0] mag_b;

  logic signed [63:0] pm_q;
  logic signed [63:0] pc1_q;
  logic signed [63:0] pc2_q;
  logic signed [32:0] sum_q;
  logic signed [32:0] dif_q;
  logic [63:0]        num_q;
  logic [32:0]        den_q;
  div_tag_t           tag_q;

  word_t early_d;
  word_t dly_q [DivLat];
  word_t div_res;
  word_t vec_q;

  assign mag_a = a_i[31] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[31] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q      <= a_i * b_i;
      pc1_q     <= aj_i * bk_i;
      pc2_q     <= ak_i * bj_i;
      sum_q     <= 33'(a_i) + 33'(b_i);
      dif_q     <= 33'(a_i) - 33'(b_i);
      num_q     <= 64'(mag_a) << FracBits;
      den_q     <= {1'b0, mag_b};
      tag_q.neg <= a_i[31] ^ b_i[31];
      tag_q.zero <= (mag_b <= 32'(ZeroTol));
      tag_q.ovf <= (64'(mag_a) << FracBits) >= (64'(mag_b) << 32);
    end
  end

  always_comb begin
    case (mode_i)
      MODE_CROSS: early_d = sat32((66'(pc1_q) - 66'(pc2_q) + HalfFrac) >>> FracBits);
      MODE_ADD:   early_d = sat32(66'(sum_q));
      MODE_SUB:   early_d = sat32(66'(dif_q));
      MODE_MUL:   early_d = sat32((66'(pm_q) + HalfFrac) >>> FracBits);
      default:    early_d = '0;
    endcase
  end

  va3_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (den_q),
    .tag_i (tag_q),
    .quo_o (div_res)
  );

  // The non-divide result waits here while the divider works.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= early_d;
      for (int k = 1; k < DivLat; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
      vec_q <= (mode_i == MODE_DIV) ? div_res : dly_q[DivLat-1];
    end
  end

  assign vec_o  = vec_q;
  assign prod_o = pm_q;

endmodule

// ===== rtl/va3_angle.sv =====
// Angle between two vectors in degrees: normalize, unit dot, acos polynomial, scale.
// Depends on va3_pkg, va3_sqrt, va3_div.
module va3_angle (
  input  logic           clk_i,
  input  logic           en_i,
  input  va3_pkg::word_t a_i [3],
  input  va3_pkg::word_t b_i [3],
  output va3_pkg::word_t deg_o
);
  import va3_pkg::*;

  localparam int PolyDly = SqrtLat - PolyLat;

  logic [63:0] sqa_q [3];
  logic [63:0] sqb_q [3];
  word_t       a1_q  [3];
  word_t       b1_q  [3];
  logic [63:0] na_q;
  logic [63:0] nb_q;
  word_t       a2_q  [3];
  word_t       b2_q  [3];
  word_t       ad_q  [SqrtLat][3];
  word_t       bd_q  [SqrtLat][3];
  logic [31:0] len_a;
  logic [31:0] len_b;
  word_t       ua    [3];
  word_t       ub    [3];
  logic signed [63:0] dp_q [3];
  logic [30:0] x_q;
  logic        neg_q;

  // Squared norms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        logic [31:0] ma;
        logic [31:0] mb;
        ma = a_i[i][31] ? (~a_i[i] + 1'b1) : a_i[i];
        mb = b_i[i][31] ? (~b_i[i] + 1'b1) : b_i[i];
        sqa_q[i] <= ma * ma;
        sqb_q[i] <= mb * mb;
        a1_q[i]  <= a_i[i];
        b1_q[i]  <= b_i[i];
      end
      na_q <= sqa_q[0] + sqa_q[1] + sqa_q[2];
      nb_q <= sqb_q[0] + sqb_q[1] + sqb_q[2];
      a2_q <= a1_q;
      b2_q <= b1_q;
      ad_q[0] <= a2_q;
      bd_q[0] <= b2_q;
      for (int k = 1; k < SqrtLat; k++) begin
        ad_q[k] <= ad_q[k-1];
        bd_q[k] <= bd_q[k-1];
      end
    end
  end

  va3_sqrt u_len_a (.clk_i(clk_i), .en_i(en_i), .rad_i(na_q), .root_o(len_a));
  va3_sqrt u_len_b (.clk_i(clk_i), .en_i(en_i), .rad_i(nb_q), .root_o(len_b));

  // Unit vectors in Q30; a zero-length vector gives zero.
  for (genvar i = 0; i < 3; i++) begin : g_unit
    word_t       va;
    word_t       vb;
    logic [31:0] ma;
    logic [31:0] mb;
    div_tag_t    ta;
    div_tag_t    tb;

    assign va = ad_q[SqrtLat-1][i];
    assign vb = bd_q[SqrtLat-1][i];
    assign ma = va[31] ? (~va + 1'b1) : va;
    assign mb = vb[31] ? (~vb + 1'b1) : vb;
    assign ta = '{neg: va[31], zero: (len_a == '0), ovf: 1'b0};
    assign tb = '{neg: vb[31], zero: (len_b == '0), ovf: 1'b0};

    va3_div u_div_a (
      .clk_i (clk_i), .en_i (en_i), .num_i (64'(ma) << 30),
      .den_i ({1'b0, len_a}), .tag_i (ta), .quo_o (ua[i])
    );
    va3_div u_div_b (
      .clk_i (clk_i), .en_i (en_i), .num_i (64'(mb) << 30),
      .den_i ({1'b0, len_b}), .tag_i (tb), .quo_o (ub[i])
    );
  end

  // Unit dot, rounded and clamped to [-1, 1].
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic signed [65:0] c;
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= ua[i] * ub[i];
      end
      c = (66'(dp_q[0]) + 66'(dp_q[1]) + 66'(dp_q[2]) + HalfQ30) >>> 30;
      if (c > OneQ30) begin
        x_q   <= Q30One;
        neg_q <= 1'b0;
      end else if (c < -OneQ30) begin
        x_q   <= Q30One;
        neg_q <= 1'b1;
      end else begin
        neg_q <= c[65];
        x_q   <= c[65] ? 31'(-c) : 31'(c);
      end
    end
  end

  // Horner evaluation of the polynomial, one multiply stage and one add stage per term.
  logic signed [65:0] pm_q [PolySteps];
  logic signed [33:0] pa_q [PolySteps];
  logic [30:0]        xm_q [PolySteps];
  logic [30:0]        xa_q [PolySteps];
  logic               nm_q [PolySteps];
  logic               na2_q [PolySteps];

  for (genvar j = 0; j < PolySteps; j++) begin : g_poly
    logic signed [33:0] p_in;
    logic [30:0]        x_in;
    logic               n_in;

    if (j == 0) begin : g_first
      assign p_in = AcosPoly[PolySteps];
      assign x_in = x_q;
      assign n_in = neg_q;
    end else begin : g_next
      assign p_in = pa_q[j-1];
      assign x_in = xa_q[j-1];
      assign n_in = na2_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pm_q[j]  <= p_in * $signed({1'b0, x_in});
        xm_q[j]  <= x_in;
        nm_q[j]  <= n_in;
        pa_q[j]  <= AcosPoly[PolySteps-1-j] + 34'((pm_q[j] + HalfQ30) >>> 30);
        xa_q[j]  <= xm_q[j];
        na2_q[j] <= nm_q[j];
      end
    end
  end

  logic [31:0]        root_s;
  logic signed [33:0] pd_q [PolyDly];
  logic               nd_q [PolyDly];
  logic signed [65:0] sp_q;
  logic               ns_q;
  logic signed [33:0] r_q;
  logic signed [67:0] rm_q;
  word_t              deg_q;

  va3_sqrt u_sqrt_x (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (64'(Q30One - x_q) << 30),
    .root_o (root_s)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic signed [33:0] r;
      pd_q[0] <= pa_q[PolySteps-1];
      nd_q[0] <= na2_q[PolySteps-1];
      for (int k = 1; k < PolyDly; k++) begin
        pd_q[k] <= pd_q[k-1];
        nd_q[k] <= nd_q[k-1];
      end
      sp_q <= $signed({1'b0, root_s[30:0]}) * pd_q[PolyDly-1];
      ns_q <= nd_q[PolyDly-1];
      r = 34'((sp_q + HalfQ30) >>> 30);
      // Negative cosines fold back through pi minus the angle of the magnitude.
      r_q  <= ns_q ? (PiQ30 - r) : r;
      rm_q <= r_q * DegQ24;
      deg_q <= sat32(66'((rm_q + HalfDeg) >>> DegShift));
    end
  end

  assign deg_o = deg_q;

endmodule

// ===== rtl/va3_merge.sv =====
// Merge stage: sums the lane products into the dot, aligns lane and angle results
// and picks the output word by mode. Depends on va3_pkg.
module va3_merge (
  input  logic               clk_i,
  input  logic               en_i,
  input  va3_pkg::mode_e     mode_i,
  input  va3_pkg::word_t     vec_i  [3],
  input  logic signed [63:0] prod_i [3],
  input  va3_pkg::word_t     deg_i,
  output va3_pkg::word_t     vec_o  [3],
  output va3_pkg::word_t     scalar_o
);
  import va3_pkg::*;

  localparam int DotDly = AngLat - DotLat;
  localparam int VecDly = AngLat - LaneLat;

  logic signed [65:0] dsum_q;
  word_t              dot_q;
  word_t              ddl_q [DotDly];
  word_t              vdl_q [VecDly][3];
  word_t              vec_q [3];
  word_t              scl_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsum_q   <= 66'(prod_i[0]) + 66'(prod_i[1]) + 66'(prod_i[2]);
      dot_q    <= sat32((dsum_q + HalfFrac) >>> FracBits);
      ddl_q[0] <= dot_q;
      vdl_q[0] <= vec_i;
      for (int k = 1; k < DotDly; k++) begin
        ddl_q[k] <= ddl_q[k-1];
      end
      for (int k = 1; k < VecDly; k++) begin
        vdl_q[k] <= vdl_q[k-1];
      end
      case (mode_i) inside
        MODE_DOT: begin
          vec_q <= '{default: '0};
          scl_q <= ddl_q[DotDly-1];
        end
        MODE_ANGLE: begin
          vec_q <= '{default: '0};
          scl_q <= deg_i;
        end
        MODE_CROSS, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
          vec_q <= vdl_q[VecDly-1];
          scl_q <= '0;
        end
        default: begin
          vec_q <= '{default: '0};
          scl_q <= '0;
        end
      endcase
    end
  end

  assign vec_o    = vec_q;
  assign scalar_o = scl_q;

endmodule

// ===== rtl/vector3_two_operand_alu.sv =====
// Top level of the three-component vector ALU on Q16.16 operands.
// Depends on va3_pkg, va3_lane, va3_angle, va3_merge.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+------------------------------------------
//   input    | in_valid_i  | in_stall_o  | a_x_i a_y_i a_z_i b_x_i b_y_i b_z_i
//   output   | out_valid_o | out_stall_i | out_x_o out_y_o out_z_o out_scalar_o
//   config   | cfg_we_i    | none        | cfg_idx_i cfg_data_i
//
// One word is taken every cycle while in_stall_o is low; the depth of the pipeline is set by
// the angle path (two 32-stage square roots and a 33-stage divider in series).
// The whole pipeline holds while a finished result waits under stall, so in_stall_o follows
// out_valid_o and out_stall_i. A word with both operands on the default vector leaves no result.
// Reset clears the mode and default-vector registers and the valid bits, and sets both use-default flags.
module vector3_two_operand_alu (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  va3_pkg::word_t a_x_i,
  input  va3_pkg::word_t a_y_i,
  input  va3_pkg::word_t a_z_i,
  input  va3_pkg::word_t b_x_i,
  input  va3_pkg::word_t b_y_i,
  input  va3_pkg::word_t b_z_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output va3_pkg::word_t out_x_o,
  output va3_pkg::word_t out_y_o,
  output va3_pkg::word_t out_z_o,
  output va3_pkg::word_t out_scalar_o
);
  import va3_pkg::*;

  mode_e mode_q;
  word_t def_q [3];
  logic  adef_q;
  logic  bdef_q;

  logic        adv;
  // One valid bit for the operand registers, one per angle stage and one for the merge stage.
  logic [AngLat+1:0] vld_q;
  word_t       as_q [3];
  word_t       bs_q [3];
  word_t       lane_vec  [3];
  logic signed [63:0] lane_prod [3];
  word_t       deg;
  word_t       res_vec [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DOT;
      def_q  <= '{default: '0};
      adef_q <= 1'b1;
      bdef_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode: mode_q   <= mode_e'(cfg_data_i[2:0]);
        RegDefX: def_q[0] <= word_t'(cfg_data_i);
        RegDefY: def_q[1] <= word_t'(cfg_data_i);
        RegDefZ: def_q[2] <= word_t'(cfg_data_i);
        RegADef: adef_q   <= cfg_data_i[0];
        RegBDef: bdef_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv        = !vld_q[AngLat+1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[AngLat:0], in_valid_i && !(adef_q && bdef_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      as_q <= adef_q ? def_q : '{a_x_i, a_y_i, a_z_i};
      bs_q <= bdef_q ? def_q : '{b_x_i, b_y_i, b_z_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    va3_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .mode_i (mode_q),
      .a_i    (as_q[i]),
      .b_i    (bs_q[i]),
      .aj_i   (as_q[(i+1)%3]),
      .bk_i   (bs_q[(i+2)%3]),
      .ak_i   (as_q[(i+2)%3]),
      .bj_i   (bs_q[(i+1)%3]),
      .vec_o  (lane_vec[i]),
      .prod_o (lane_prod[i])
    );
  end

  va3_angle u_angle (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (as_q),
    .b_i   (bs_q),
    .deg_o (deg)
  );

  va3_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (adv),
    .mode_i   (mode_q),
    .vec_i    (lane_vec),
    .prod_i   (lane_prod),
    .deg_i    (deg),
    .vec_o    (res_vec),
    .scalar_o (out_scalar_o)
  );

  assign out_valid_o = vld_q[AngLat+1];
  assign out_x_o     = res_vec[0];
  assign out_y_o     = res_vec[1];
  assign out_z_o     = res_vec[2];

  // The pipeline must take a word whenever no finished result is held back.
  a_take_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the output side is free");

  // A word with both operands on the default vector must not enter as a live word.
  a_drop_both_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && adef_q && bdef_q) |=> !vld_q[0])
    else $error("word with both operands unconnected entered the pipeline");

endmodule
